// ===== design/font_cmap_glyph_lookup_assert.svh =====
// Assertion macros for the character-map glyph lookup block.
`ifndef FONT_CMAP_GLYPH_LOOKUP_ASSERT_SVH
`define FONT_CMAP_GLYPH_LOOKUP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define FCG_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication checked in the cycle after the condition.
`define FCG_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== design/fcg_pkg.sv =====
// Package with the constants and types of the glyph lookup block.
`timescale 1ns / 1ps
package fcg_pkg;
  localparam int TableWordsDef  = 4096;
  localparam int MaxSegmentsDef = 512;
  localparam logic [1:0] FMT_BYTE    = 2'd0;
  localparam logic [1:0] FMT_HIGH    = 2'd1;
  localparam logic [1:0] FMT_SEGMENT = 2'd2;
  localparam logic [1:0] FMT_UNUSED  = 2'd3;
  localparam logic       OP_WRITE    = 1'b0;
  localparam logic       OP_LOOKUP   = 1'b1;
  localparam logic       CFG_FORMAT  = 1'b0;
  localparam logic       CFG_SEGS    = 1'b1;
  localparam logic [15:0] GlyphMissing = 16'h0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_F0, ST_F2_KEY, ST_F2_FIRST, ST_F2_COUNT, ST_F2_DELTA, ST_F2_RO,
    ST_F2_GLYPH, ST_F4_END, ST_F4_START, ST_F4_DELTA, ST_F4_RO, ST_F4_GLYPH,
    ST_DONE
  } state_e;

  // Read request from the sequencer to the table memory.
  typedef struct packed {
    logic        en;
    logic [31:0] addr;
  } rd_req_t;
endpackage

// ===== design/fcg_table_ram.sv =====
// Table word memory with one write port and one registered read port.
`timescale 1ns / 1ps
module fcg_table_ram #(
  parameter int TableWords = fcg_pkg::TableWordsDef
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(TableWords)-1:0] waddr_i,
  input  logic [15:0]                   wdata_i,
  input  fcg_pkg::rd_req_t              rd_i,
  output logic [15:0]                   rdata_o
);
  localparam int AW = $clog2(TableWords);
  logic [15:0] mem [TableWords];
  logic        oor_q;
  logic [15:0] raw_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; addresses beyond the table read as zero.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      raw_q <= mem[rd_i.addr[AW-1:0]];
      oor_q <= (rd_i.addr >= 32'(TableWords));
    end
  end

  assign rdata_o = oor_q ? 16'h0000 : raw_q;
endmodule

// ===== design/fcg_sequencer.sv =====
// Lookup sequencer that walks the table one memory read per step.
`timescale 1ns / 1ps
module fcg_sequencer #(
  parameter int MaxSegments = fcg_pkg::MaxSegmentsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      code_i,
  input  logic [1:0]       format_i,
  input  logic [9:0]       segs_i,
  input  logic [15:0]      rdata_i,
  output fcg_pkg::rd_req_t rd_o,
  output logic             busy_o,
  output logic             done_o,
  output logic [15:0]      glyph_o
);
  localparam int SW = $clog2(MaxSegments + 1) > 10 ? $clog2(MaxSegments + 1) : 10;
  fcg_pkg::state_e state_q, state_d;
  logic [31:0] code_q;
  logic [SW-1:0] segs_q, segs_d, idx_q, idx_d;
  logic [15:0] a_q, a_d, c_q, c_d, g_q, g_d;
  logic [31:0] base_q, base_d;
  logic [15:0] lo16;
  logic [SW-1:0] segs_in;

  assign lo16 = {8'h00, code_q[7:0]};
  assign segs_in = (SW'(segs_i) > SW'(MaxSegments)) ? SW'(MaxSegments) : SW'(segs_i);

  // State and working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      code_q <= code_i;
    end
    segs_q <= segs_d;
    idx_q  <= idx_d;
    a_q    <= a_d;
    c_q    <= c_d;
    g_q    <= g_d;
    base_q <= base_d;
  end

  // Next state, memory requests and the result.
  always_comb begin
    state_d = state_q;
    segs_d = segs_q;
    idx_d = idx_q;
    a_d = a_q;
    c_d = c_q;
    g_d = g_q;
    base_d = base_q;
    rd_o.en = 1'b0;
    rd_o.addr = 32'd0;
    case (state_q)
      fcg_pkg::ST_IDLE: begin
        if (start_i) begin
          g_d = fcg_pkg::GlyphMissing;
          segs_d = segs_in;
          idx_d = '0;
          case (format_i)
            fcg_pkg::FMT_BYTE: begin
              if (code_i > 32'hFF) begin
                state_d = fcg_pkg::ST_DONE;
              end else begin
                rd_o.en = 1'b1;
                rd_o.addr = 32'd3 + {1'b0, code_i[31:1]};
                state_d = fcg_pkg::ST_F0;
              end
            end
            fcg_pkg::FMT_HIGH: begin
              if (code_i > 32'hFFFF) begin
                state_d = fcg_pkg::ST_DONE;
              end else begin
                rd_o.en = 1'b1;
                rd_o.addr = 32'd3 + 32'(code_i[15:8]);
                state_d = fcg_pkg::ST_F2_KEY;
              end
            end
            fcg_pkg::FMT_SEGMENT: begin
              if (code_i > 32'hFFFF || segs_in == '0) begin
                state_d = fcg_pkg::ST_DONE;
              end else begin
                rd_o.en = 1'b1;
                rd_o.addr = 32'd7;
                state_d = fcg_pkg::ST_F4_END;
              end
            end
            default: state_d = fcg_pkg::ST_DONE;
          endcase
        end
      end
      fcg_pkg::ST_F0: begin
        g_d = code_q[0] ? {8'h00, rdata_i[7:0]} : {8'h00, rdata_i[15:8]};
        state_d = fcg_pkg::ST_DONE;
      end
      fcg_pkg::ST_F2_KEY: begin
        base_d = 32'd259 + 32'({rdata_i[15:3], 2'b00});
        rd_o.en = 1'b1;
        rd_o.addr = 32'd259 + 32'({rdata_i[15:3], 2'b00});
        state_d = fcg_pkg::ST_F2_FIRST;
      end
      fcg_pkg::ST_F2_FIRST: begin
        a_d = rdata_i;
        rd_o.en = 1'b1;
        rd_o.addr = base_q + 32'd1;
        state_d = fcg_pkg::ST_F2_COUNT;
      end
      fcg_pkg::ST_F2_COUNT: begin
        rd_o.en = 1'b1;
        rd_o.addr = base_q + 32'd2;
        if (lo16 < a_q || (lo16 - a_q) >= rdata_i) begin
          state_d = fcg_pkg::ST_DONE;
        end else begin
          state_d = fcg_pkg::ST_F2_DELTA;
        end
      end
      fcg_pkg::ST_F2_DELTA: begin
        c_d = rdata_i;
        rd_o.en = 1'b1;
        rd_o.addr = base_q + 32'd3;
        state_d = fcg_pkg::ST_F2_RO;
      end
      fcg_pkg::ST_F2_RO: begin
        rd_o.en = 1'b1;
        rd_o.addr = base_q + 32'd3 + 32'(rdata_i[15:1]) + 32'(lo16 - a_q);
        state_d = fcg_pkg::ST_F2_GLYPH;
      end
      fcg_pkg::ST_F2_GLYPH, fcg_pkg::ST_F4_GLYPH: begin
        g_d = (rdata_i == fcg_pkg::GlyphMissing) ? fcg_pkg::GlyphMissing : rdata_i + c_q;
        state_d = fcg_pkg::ST_DONE;
      end
      fcg_pkg::ST_F4_END: begin
        // One end code per cycle; the read for the next one is issued now.
        if (32'(rdata_i) >= code_q) begin
          rd_o.en = 1'b1;
          rd_o.addr = 32'd8 + 32'(segs_q) + 32'(idx_q);
          state_d = fcg_pkg::ST_F4_START;
        end else if (idx_q + 1'b1 >= segs_q) begin
          state_d = fcg_pkg::ST_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
          rd_o.en = 1'b1;
          rd_o.addr = 32'd8 + 32'(idx_q);
        end
      end
      fcg_pkg::ST_F4_START: begin
        a_d = rdata_i;
        rd_o.en = 1'b1;
        rd_o.addr = 32'd8 + 32'({segs_q, 1'b0}) + 32'(idx_q);
        state_d = (code_q[15:0] < rdata_i) ? fcg_pkg::ST_DONE : fcg_pkg::ST_F4_DELTA;
      end
      fcg_pkg::ST_F4_DELTA: begin
        c_d = rdata_i;
        base_d = 32'd8 + 32'(segs_q) * 32'd3 + 32'(idx_q);
        rd_o.en = 1'b1;
        rd_o.addr = 32'd8 + 32'(segs_q) * 32'd3 + 32'(idx_q);
        state_d = fcg_pkg::ST_F4_RO;
      end
      fcg_pkg::ST_F4_RO: begin
        if (rdata_i == 16'h0000) begin
          g_d = code_q[15:0] + c_q;
          state_d = fcg_pkg::ST_DONE;
        end else begin
          rd_o.en = 1'b1;
          rd_o.addr = base_q + 32'(rdata_i[15:1]) + 32'(code_q[15:0] - a_q);
          state_d = fcg_pkg::ST_F4_GLYPH;
        end
      end
      fcg_pkg::ST_DONE: state_d = fcg_pkg::ST_IDLE;
      default: state_d = fcg_pkg::ST_IDLE;
    endcase
  end

  assign busy_o  = (state_q != fcg_pkg::ST_IDLE);
  assign done_o  = (state_q == fcg_pkg::ST_DONE);
  assign glyph_o = g_q;
endmodule

// ===== design/font_cmap_glyph_lookup.sv =====
// Top level of the character-map glyph lookup block.
`timescale 1ns / 1ps
// Maps code units to glyph indices from a cmap subtable held in an on-chip word
// memory. A lookup holds off the input while it runs: format 0 reads one table
// word, format 2 reads the subheader key and up to five more words, and format 4
// reads one end code per segment compared and then up to four more words. Codes
// above the format limit and the unused format code finish without a table
// read. The single read port of the table memory makes these reads run one after
// another. One lookup is in work at a time; its result sits in an output
// register while the next transaction is taken, and a result that waits on the
// receiver holds off the input. The table has no reset.
module font_cmap_glyph_lookup #(
  parameter int TableWords  = fcg_pkg::TableWordsDef,
  parameter int MaxSegments = fcg_pkg::MaxSegmentsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [11:0] word_slot_i,
  input  logic [15:0] word_value_i,
  input  logic [31:0] code_unit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] glyph_number_o
);
  `include "font_cmap_glyph_lookup_assert.svh"
  localparam int AW = $clog2(TableWords);
  logic [1:0] format_q;
  logic [9:0] segs_q;
  logic in_acc, we, start, busy, done;
  logic [15:0] rdata, glyph;
  fcg_pkg::rd_req_t rd;
  logic out_valid_q;
  logic [15:0] out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= fcg_pkg::FMT_BYTE;
      segs_q   <= 10'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == fcg_pkg::CFG_FORMAT) begin
        format_q <= cfg_data_i[1:0];
      end else begin
        segs_q <= cfg_data_i;
      end
    end
  end

  // Input handshake: hold off while a lookup runs or a result waits.
  assign in_stall_o = busy || (out_valid_q && out_stall_i);
  assign in_acc = in_valid_i && !in_stall_o;
  assign we = in_acc && opcode_i == fcg_pkg::OP_WRITE && 32'(word_slot_i) < 32'(TableWords);
  assign start = in_acc && opcode_i == fcg_pkg::OP_LOOKUP;

  fcg_table_ram #(.TableWords(TableWords)) u_ram (
    .clk_i, .we_i(we), .waddr_i(AW'(word_slot_i)), .wdata_i(word_value_i),
    .rd_i(rd), .rdata_o(rdata)
  );

  fcg_sequencer #(.MaxSegments(MaxSegments)) u_seq (
    .clk_i, .rst_ni, .start_i(start), .code_i(code_unit_i), .format_i(format_q),
    .segs_i(segs_q), .rdata_i(rdata), .rd_o(rd), .busy_o(busy), .done_o(done),
    .glyph_o(glyph)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= glyph;
    end
  end

  assign out_valid_o = out_valid_q;
  assign glyph_number_o = out_q;

  `FCG_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, done, !(out_valid_q && out_stall_i))
  `FCG_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start, busy)
  `FCG_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, busy, in_stall_o)
endmodule

// ===== tb/fcg_lookup_checker.sv =====
// Checker that predicts and compares the glyph lookup results.
`timescale 1ns / 1ps
module fcg_lookup_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        opcode_i,
  input  logic [11:0] word_slot_i,
  input  logic [15:0] word_value_i,
  input  logic [31:0] code_unit_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] glyph_number_i,
  output int          mismatch_count_o,
  output int          glyphs_pending_o,
  output int          glyphs_checked_o,
  output int          words_written_o
);
  import fcg_pkg::*;

  localparam int unsigned TableWords  = TableWordsDef;
  localparam int unsigned MaxSegments = MaxSegmentsDef;

  logic [15:0] cmap_words [TableWords];
  logic [1:0]  cur_format;
  logic [9:0]  cur_segments;
  logic [15:0] expected_glyphs [$];

  // Table read; addresses past the end read as zero.
  function automatic int unsigned word_at(int unsigned addr);
    if (addr >= TableWords) return 0;
    return cmap_words[addr];
  endfunction

  // Computes the glyph that a lookup of the given code must return.
  function automatic logic [15:0] predict_glyph(logic [31:0] code);
    int unsigned hi, lo, key, sub, first, count, delta, ro, idx, g;
    int unsigned segs, i, start, ro_addr;
    bit found;
    found = 0;
    case (cur_format)
      FMT_BYTE: begin
        if (code > 32'hFF) return GlyphMissing;
        g = word_at(3 + (code >> 1));
        return code[0] ? 16'(g & 8'hFF) : 16'((g >> 8) & 8'hFF);
      end
      FMT_HIGH: begin
        if (code > 32'hFFFF) return GlyphMissing;
        hi = (code >> 8) & 8'hFF;
        lo = code & 8'hFF;
        key = word_at(3 + hi);
        sub = 259 + ((key >> 3) << 2);
        first = word_at(sub);
        count = word_at(sub + 1);
        delta = word_at(sub + 2);
        ro = word_at(sub + 3);
        if (lo < first) return GlyphMissing;
        idx = lo - first;
        if (idx >= count) return GlyphMissing;
        g = word_at(sub + 3 + (ro >> 1) + idx);
        if (g == 0) return GlyphMissing;
        return 16'(g + delta);
      end
      FMT_SEGMENT: begin
        if (code > 32'hFFFF) return GlyphMissing;
        segs = (cur_segments > MaxSegments) ? MaxSegments : cur_segments;
        for (i = 0; i < segs; i++) begin
          if (word_at(7 + i) >= code) begin
            found = 1;
            break;
          end
        end
        if (!found) return GlyphMissing;
        start = word_at(8 + segs + i);
        if (code < start) return GlyphMissing;
        delta = word_at(8 + 2 * segs + i);
        ro_addr = 8 + 3 * segs + i;
        ro = word_at(ro_addr);
        if (ro == 0) return 16'(code + delta);
        g = word_at(ro_addr + (ro >> 1) + (code - start));
        if (g == 0) return GlyphMissing;
        return 16'(g + delta);
      end
      default: return GlyphMissing;
    endcase
  endfunction

  assign glyphs_pending_o = expected_glyphs.size();

  // Watch both channels and the register port at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_format <= FMT_BYTE;
      cur_segments <= 10'd1;
      mismatch_count_o <= 0;
      glyphs_checked_o <= 0;
      words_written_o <= 0;
      expected_glyphs.delete();
    end else begin
      // Results first: a result never belongs to a transaction taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_glyphs.size() == 0) begin
          $display("%0t: unexpected glyph result, expected none, actual %h",
                   $time, glyph_number_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          if (glyph_number_i !== expected_glyphs[0]) begin
            $display("%0t: glyph_number mismatch, expected %h, actual %h",
                     $time, expected_glyphs[0], glyph_number_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
          void'(expected_glyphs.pop_front());
          glyphs_checked_o <= glyphs_checked_o + 1;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_WRITE) begin
          cmap_words[word_slot_i] = word_value_i;
          words_written_o <= words_written_o + 1;
        end else begin
          expected_glyphs.push_back(predict_glyph(code_unit_i));
        end
      end
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FORMAT) cur_format <= cfg_data_i[1:0];
        else cur_segments <= cfg_data_i;
      end
    end
  end
endmodule

// ===== tb/font_cmap_glyph_lookup_tb.sv =====
// Testbench top that drives the glyph lookup block and reports the verdict.
`timescale 1ns / 1ps
module font_cmap_glyph_lookup_tb;
  import fcg_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = CFG_FORMAT;
  logic [9:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        opcode_i = OP_WRITE;
  logic [11:0] word_slot_i = '0;
  logic [15:0] word_value_i = '0;
  logic [31:0] code_unit_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] glyph_number_o;

  int mismatch_count, glyphs_pending, glyphs_checked, words_written;
  bit quiet_run = 1'b0;
  bit long_hold_req = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  font_cmap_glyph_lookup dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .opcode_i, .word_slot_i, .word_value_i,
    .code_unit_i, .out_valid_o, .out_stall_i, .glyph_number_o
  );

  fcg_lookup_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .word_slot_i,
    .word_value_i, .code_unit_i, .out_valid_i(out_valid_o), .out_stall_i,
    .glyph_number_i(glyph_number_o),
    .mismatch_count_o(mismatch_count), .glyphs_pending_o(glyphs_pending),
    .glyphs_checked_o(glyphs_checked), .words_written_o(words_written)
  );

  // Offers one transaction and holds it until the block takes it.
  task automatic send_item(logic op, logic [11:0] slot, logic [15:0] value,
                           logic [31:0] code);
    if (!quiet_run && $urandom_range(0, 9) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    opcode_i = op;
    word_slot_i = slot;
    word_value_i = value;
    code_unit_i = code;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stops offering and waits until every lookup has returned.
  task automatic drain_lookups();
    in_valid_i = 1'b0;
    while (glyphs_pending != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [9:0] value);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic [15:0] table_value();
    return ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom);
  endfunction

  // Random transaction shaped for the format in use, mostly lookups.
  task automatic random_item(logic [1:0] fmt, int segs);
    logic [11:0] slot;
    logic [15:0] value;
    logic [31:0] code;
    int sel;
    sel = $urandom_range(0, 99);
    code = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 16'hFFFF));
    if (fmt == FMT_BYTE && $urandom_range(0, 9) != 0) code = $urandom_range(0, 255);
    if (fmt == FMT_HIGH && $urandom_range(0, 1) == 0)
      code = {16'h0, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 40))};
    if (sel < 70) begin
      send_item(OP_LOOKUP, 12'($urandom), 16'($urandom), code);
    end else begin
      value = table_value();
      case (fmt)
        FMT_BYTE: slot = 12'($urandom_range(3, 130));
        FMT_HIGH: begin
          if (sel < 80) begin
            slot = 12'($urandom_range(3, 258));
            value = 16'($urandom_range(0, 7) << 3);
          end else begin
            slot = 12'($urandom_range(259, 400));
          end
        end
        FMT_SEGMENT: slot = 12'($urandom_range(7, 8 + 4 * segs + 40));
        default: slot = 12'($urandom);
      endcase
      send_item(OP_WRITE, slot, value, $urandom);
    end
  endtask

  // One configuration setting: directed edge codes, then random traffic.
  task automatic run_setting(logic [1:0] fmt, logic [9:0] segs, int items);
    logic [31:0] edge_codes [6];
    int eff_segs;
    edge_codes = '{32'h0, 32'hFF, 32'h100, 32'hFFFF, 32'h10000, 32'hFFFF_FFFF};
    eff_segs = (segs > 512) ? 512 : segs;
    drain_lookups();
    write_register(CFG_FORMAT, {8'h0, fmt});
    write_register(CFG_SEGS, segs);
    foreach (edge_codes[k]) send_item(OP_LOOKUP, 12'hFFF, 16'hFFFF, edge_codes[k]);
    repeat (items) random_item(fmt, eff_segs);
  endtask

  // Receiver: random stall bursts plus one long hold on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        out_stall_i = 1'b1;
        repeat (300) @(negedge clk_i);
        long_hold_req = 1'b0;
        out_stall_i = 1'b0;
      end else if (!quiet_run && $urandom_range(0, 9) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Fill the whole table so that no lookup reads a word never written.
    for (int i = 0; i < 4096; i++) send_item(OP_WRITE, 12'(i), 16'($urandom), $urandom);
    run_setting(FMT_BYTE, 10'd1, 150);
    run_setting(FMT_HIGH, 10'd1, 40);
    long_hold_req = 1'b1;
    repeat (160) random_item(FMT_HIGH, 1);
    run_setting(FMT_SEGMENT, 10'd4, 200);
    run_setting(FMT_SEGMENT, 10'd0, 30);
    run_setting(FMT_SEGMENT, 10'd1, 50);
    run_setting(FMT_SEGMENT, 10'd1023, 20);
    run_setting(FMT_SEGMENT, 10'd512, 20);
    run_setting(FMT_UNUSED, 10'd16, 30);
    quiet_run = 1'b1;
    run_setting(FMT_SEGMENT, 10'd16, 150);
    drain_lookups();
    $display("Covered table fill, all formats incl. the unused code, segment counts 0 to 1023;");
    $display("  %0d table words written, %0d glyph lookups checked.",
             words_written, glyphs_checked);
    if (mismatch_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d lookups outstanding.", glyphs_pending);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

// ===== font_cmap_glyph_lookup.f =====
+incdir+design
design/fcg_pkg.sv
design/fcg_table_ram.sv
design/fcg_sequencer.sv
design/font_cmap_glyph_lookup.sv
tb/fcg_lookup_checker.sv
tb/font_cmap_glyph_lookup_tb.sv
